/* rtl/dip_pkg.sv */
package dip_pkg;

  // Width of the internal consumed-character counter.
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  // Register indexes on the configuration port.
  localparam logic REG_SIGNED_MODE = 1'b0;
  localparam logic REG_SKIP_SPACE  = 1'b1;

  localparam logic [63:0] TENTH_MAX = 64'd1844674407370955161;
  localparam logic [63:0] POS_LIMIT = 64'd9223372036854775807;
  localparam logic [63:0] NEG_LIMIT = 64'd9223372036854775808;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic signed_mode;
    logic skip_leading_space;
  } cfg_t;

  // Raw token state captured when the terminator arrives.
  typedef struct packed {
    logic [63:0]           acc;
    logic                  overflow;
    logic                  negative;
    logic                  digit_seen;
    logic                  signed_mode;
    logic [COUNT_BITS-1:0] count;
  } token_t;

  function automatic logic [15:0] sat_count(input logic [COUNT_BITS-1:0] count);
    logic [31:0] c32;
    c32 = 32'(count);
    return (c32 > 32'h0000_ffff) ? 16'hffff : c32[15:0];
  endfunction

endpackage

/* rtl/dip_cfg.sv */
module dip_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dip_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [dip_pkg::DATA_BITS-1:0]   pwdata,
  output logic [dip_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  output dip_pkg::cfg_t                   cfg_o
);

  dip_pkg::cfg_t cfg_q;
  logic          reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dip_pkg::ADDR_BITS-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode        <= 1'b1;
      cfg_q.skip_leading_space <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        dip_pkg::REG_SIGNED_MODE: cfg_q.signed_mode        <= pwdata[0];
        dip_pkg::REG_SKIP_SPACE:  cfg_q.skip_leading_space <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dip_pkg::REG_SIGNED_MODE: prdata[0] = cfg_q.signed_mode;
      dip_pkg::REG_SKIP_SPACE:  prdata[0] = cfg_q.skip_leading_space;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/dip_step.sv */
module dip_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dip_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       ch_i,
  output logic             tok_valid_o,
  input  logic             tok_ready_i,
  output dip_pkg::token_t  tok_o
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  logic [7:0]                     ch_q;
  logic                           chv_q;
  logic [1:0]                     phase_q, phase_d;
  logic                           neg_q, neg_d;
  logic [63:0]                    acc_q, acc_d;
  logic                           ovf_q, ovf_d;
  logic                           dseen_q, dseen_d;
  logic [dip_pkg::COUNT_BITS-1:0] count_q, count_d;
  dip_pkg::token_t                tok_q;
  logic                           tokv_q;

  logic       is_ws, is_dig, is_sgn;
  logic [3:0] digit;
  logic [1:0] ph;
  logic       take, term, adv, tok_room;

  assign is_ws  = (ch_q == dip_pkg::CH_SPACE) ||
                  ((ch_q >= dip_pkg::CH_TAB) && (ch_q <= dip_pkg::CH_CR));
  assign is_dig = (ch_q >= dip_pkg::CH_ZERO) && (ch_q <= dip_pkg::CH_NINE);
  assign is_sgn = (ch_q == dip_pkg::CH_PLUS) || (ch_q == dip_pkg::CH_MINUS);
  assign digit  = 4'(ch_q - dip_pkg::CH_ZERO);

  // The phases fall through within one beat, so a character that does not
  // fit an earlier phase is tried against the later ones.
  always_comb begin
    ph      = phase_q;
    take    = 1'b0;
    term    = 1'b0;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    dseen_d = dseen_q;
    if (ph == PH_LEAD) begin
      if (cfg_i.skip_leading_space && is_ws) begin
        take = 1'b1;
      end else begin
        ph = PH_SIGN;
      end
    end
    if (!take && ph == PH_SIGN) begin
      if (cfg_i.signed_mode && is_sgn) begin
        neg_d   = (ch_q == dip_pkg::CH_MINUS);
        take    = 1'b1;
        phase_d = PH_POST;
      end else begin
        ph = PH_DIGIT;
      end
    end
    if (!take && ph == PH_POST) begin
      if (is_ws) begin
        take = 1'b1;
      end else begin
        ph = PH_DIGIT;
      end
    end
    if (!take) begin
      if (is_dig) begin
        take    = 1'b1;
        phase_d = PH_DIGIT;
        dseen_d = 1'b1;
        if (!ovf_q) begin
          if ((acc_q > dip_pkg::TENTH_MAX) ||
              ((acc_q == dip_pkg::TENTH_MAX) && (digit > 4'd5))) begin
            ovf_d = 1'b1;
            acc_d = '1;
          end else begin
            acc_d = (acc_q << 3) + (acc_q << 1) + 64'(digit);
          end
        end
      end else begin
        term = 1'b1;
      end
    end
    count_d = (take && (count_q != dip_pkg::COUNT_MAX)) ? count_q + 1'b1 : count_q;
  end

  assign tok_room   = !tokv_q || tok_ready_i;
  assign adv        = chv_q && (!term || tok_room);
  assign in_ready_o = !chv_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chv_q <= 1'b0;
    end else if (in_ready_o) begin
      chv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      dseen_q <= 1'b0;
      count_q <= '0;
    end else if (adv) begin
      if (term) begin
        phase_q <= PH_LEAD;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        dseen_q <= 1'b0;
        count_q <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        dseen_q <= dseen_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokv_q <= 1'b0;
    end else if (adv && term) begin
      tokv_q <= 1'b1;
    end else if (tok_ready_i) begin
      tokv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && term) begin
      tok_q.acc         <= acc_q;
      tok_q.overflow    <= ovf_q;
      tok_q.negative    <= neg_q;
      tok_q.digit_seen  <= dseen_q;
      tok_q.signed_mode <= cfg_i.signed_mode;
      tok_q.count       <= count_q;
    end
  end

  assign tok_valid_o = tokv_q;
  assign tok_o       = tok_q;

endmodule

/* rtl/dip_finish.sv */
module dip_finish (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  output logic             tok_ready_o,
  input  dip_pkg::token_t  tok_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      value_o,
  output logic             found_o,
  output logic [1:0]       range_status_o,
  output logic [15:0]      consumed_count_o
);

  logic        outv_q;
  logic [63:0] value_q, value_d;
  logic        found_q;
  logic [1:0]  status_q, status_d;
  logic [15:0] count_q, count_d;
  logic        too_big;
  logic        load;

  // Magnitude limit is 2^63 for a negative number and 2^63-1 otherwise.
  assign too_big = tok_i.negative ? (tok_i.acc[63] && (|tok_i.acc[62:0])) : tok_i.acc[63];

  always_comb begin
    value_d  = '0;
    status_d = dip_pkg::ST_OK;
    count_d  = '0;
    if (tok_i.digit_seen) begin
      count_d = dip_pkg::sat_count(tok_i.count);
      if (tok_i.signed_mode) begin
        if (tok_i.overflow || too_big) begin
          value_d  = tok_i.negative ? dip_pkg::NEG_LIMIT : dip_pkg::POS_LIMIT;
          status_d = tok_i.negative ? dip_pkg::ST_UNDER : dip_pkg::ST_OVER;
        end else begin
          value_d = tok_i.negative ? (64'd0 - tok_i.acc) : tok_i.acc;
        end
      end else begin
        value_d  = tok_i.acc;
        status_d = tok_i.overflow ? dip_pkg::ST_OVER : dip_pkg::ST_OK;
      end
    end
  end

  assign tok_ready_o = !outv_q || out_ready_i;
  assign load        = tok_valid_i && tok_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (tok_ready_o) begin
      outv_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q  <= value_d;
      found_q  <= tok_i.digit_seen;
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o      = outv_q;
  assign value_o          = value_q;
  assign found_o          = found_q;
  assign range_status_o   = status_q;
  assign consumed_count_o = count_q;

endmodule

/* rtl/decimal_integer_parser_saturating.sv */
// Streaming decimal integer parser with saturation.
// Input channel: one ASCII character per beat on ch_i (in_valid_i/in_ready_o).
// Output channel: one result beat per token (out_valid_o/out_ready_i) carrying
// value_o, found_o, range_status_o and consumed_count_o. A token ends at the
// first character that does not fit it; that character gives the result and
// is not part of the next token.
// Throughput: one character per cycle while in_ready_o is high. The token
// state (64-bit accumulator, phase, sign, counter) is updated once per accepted
// character; digits enter the accumulator by a shift-and-add step. A terminator
// accepted on ch_i passes through the character register, the token register
// and the result register, in that order.
// Configuration: APB registers signed_mode (address 0) and skip_leading_space
// (address 4), both 1 after reset; change them only while the block is idle.
// Reset clears the token state and all pipeline valids.
// When the receiver stalls, the result register holds, the token register
// fills behind it, and in_ready_o drops only once a second terminator would
// need to leave the parse stage; ordinary characters keep flowing until then.
module decimal_integer_parser_saturating (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dip_pkg::ADDR_BITS-1:0] paddr,
  input  logic [dip_pkg::DATA_BITS-1:0] pwdata,
  output logic [dip_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    ch_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [63:0]                   value_o,
  output logic                          found_o,
  output logic [1:0]                    range_status_o,
  output logic [15:0]                   consumed_count_o
);

  dip_pkg::cfg_t   cfg;
  dip_pkg::token_t tok;
  logic            tok_valid;
  logic            tok_ready;

  dip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dip_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .tok_valid_o (tok_valid),
    .tok_ready_i (tok_ready),
    .tok_o       (tok)
  );

  dip_finish u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (tok_valid),
    .tok_ready_o      (tok_ready),
    .tok_i            (tok),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .found_o          (found_o),
    .range_status_o   (range_status_o),
    .consumed_count_o (consumed_count_o)
  );

  // Backpressure reaches the input only through a stalled output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled output");

  // A token without digits reports nothing else.
  a_empty_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (value_o == 64'd0 && consumed_count_o == 16'd0 &&
       range_status_o == dip_pkg::ST_OK))
    else $error("empty token with nonzero fields");

  // Underflow always saturates to the most negative int64.
  a_underflow_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == dip_pkg::ST_UNDER) |->
      (value_o == dip_pkg::NEG_LIMIT && found_o))
    else $error("underflow without saturated value");

  // The parse stage never hands a token to a full result stage.
  a_token_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid && !tok_ready) |=> tok_valid)
    else $error("token dropped while result stage was full");

endmodule
